/* rtl/gscl_pkg.sv */
// ----------------------------------------------------------------------------
// gscl_pkg: gradient stop color lookup shared definitions
// Widths, beat layouts, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package gscl_pkg;

	// table geometry
	localparam int MAX_STOPS = 16;
	localparam int IDX_W     = $clog2(MAX_STOPS);
	localparam int CNT_W     = $clog2(MAX_STOPS + 1);
	localparam int CFG_W     = 5;

	// field widths
	localparam int POS_W    = 16;
	localparam int CH_W     = 8;
	localparam int NUM_CH   = 4;
	localparam int CHSEL_W  = $clog2(NUM_CH);
	localparam int BIT_W    = $clog2(CH_W);
	localparam int PROD_W   = CH_W + POS_W;
	localparam int NUM_W    = PROD_W + 1;
	localparam int DSH_W    = POS_W + CH_W - 1;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] color_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		color_t           col;
	} stop_t;

	typedef struct packed {
		logic             command;
		logic [3:0]       stop_index;
		logic [POS_W-1:0] stop_position;
		chan_t            stop_red;
		chan_t            stop_green;
		chan_t            stop_blue;
		chan_t            stop_alpha;
		logic [POS_W-1:0] query_position;
	} req_beat_t;

	typedef struct packed {
		logic  color_valid;
		chan_t out_red;
		chan_t out_green;
		chan_t out_blue;
		chan_t out_alpha;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr;
		logic start;
		logic rd;
		logic pick;
		logic ch_init;
		logic mul;
		logic load;
		logic div;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_zero;
		logic scan_last;
		logic have_lo;
		logic have_hi;
		logic div_last;
		logic ch_last;
		logic out_busy;
	} dp_stat_t;

endpackage

/* rtl/gscl_if.sv */
// ----------------------------------------------------------------------------
// gscl_if: request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface gscl_req_if;
	import gscl_pkg::*;

	logic      valid;
	logic      ready;
	req_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gscl_rsp_if;
	import gscl_pkg::*;

	logic      valid;
	logic      ready;
	rsp_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/gscl_ctrl.sv */
// ----------------------------------------------------------------------------
// gscl_ctrl: lookup sequencer
// Issues stop writes and steps a lookup through table scan, per-channel
// multiply and divide, and hands the finished color to the output register.
// ----------------------------------------------------------------------------
module gscl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_command,
	output logic                 req_ready,
	input  gscl_pkg::dp_stat_t   stat,
	output gscl_pkg::ctrl_cmd_t  cmd
);
	import gscl_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   acc;

	assign acc = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && req_command == CMD_LOOKUP) begin
					state_nxt = stat.n_zero ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				state_nxt = (stat.have_lo && stat.have_hi) ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) begin
					state_nxt = stat.ch_last ? ST_DONE : ST_MUL;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.wr    = acc && req_command == CMD_WRITE;
				cmd.start = acc && req_command == CMD_LOOKUP;
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_EVAL: begin
				cmd.pick    = !(stat.have_lo && stat.have_hi);
				cmd.ch_init = stat.have_lo && stat.have_hi;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
			end
			ST_DONE: begin
				cmd.emit = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/gscl_dp.sv */
// ----------------------------------------------------------------------------
// gscl_dp: stop table and interpolation datapath
// Holds the stop table, tracks the nearest stops on each side during a scan,
// and interpolates one channel at a time with a restoring divider.
// ----------------------------------------------------------------------------
module gscl_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gscl_pkg::ctrl_cmd_t         cmd,
	output gscl_pkg::dp_stat_t          stat,
	input  gscl_pkg::req_beat_t         req_beat,
	input  logic                        cfg_we,
	input  logic [gscl_pkg::CFG_W-1:0]  cfg_wdata,
	output gscl_pkg::rsp_beat_t         rsp_beat,
	output logic                        rsp_valid,
	input  logic                        rsp_ready
);
	import gscl_pkg::*;

	// control state
	logic [CFG_W-1:0]   cfg_q;
	logic [IDX_W-1:0]   addr_q;
	logic               rd_vld_s1;
	logic               have_lo_q;
	logic               have_hi_q;
	logic [CHSEL_W-1:0] ch_q;
	logic [BIT_W-1:0]   bit_q;
	logic               rsp_valid_q;

	// payload state
	stop_t              mem [MAX_STOPS];
	stop_t              rd_s1;
	logic [POS_W-1:0]   qpos_q;
	logic [POS_W-1:0]   lo_pos_q;
	logic [POS_W-1:0]   hi_pos_q;
	color_t             lo_col_q;
	color_t             hi_col_q;
	logic [PROD_W-1:0]  prod_a_s1;
	logic [PROD_W-1:0]  prod_b_s1;
	logic [NUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [CH_W-1:0]    quot_q;
	logic               rslt_vld_q;
	color_t             rslt_col_q;
	rsp_beat_t          out_q;

	logic [CNT_W-1:0]   n_sat;
	logic               single;
	stop_t              wr_entry;
	logic               lo_upd;
	logic               hi_upd;
	logic [POS_W-1:0]   span;
	logic [POS_W-1:0]   np_q;
	logic [POS_W-1:0]   q_pp;
	logic               ge;
	logic [CH_W-1:0]    quot_nxt;

	// stop count, saturated to the table depth
	always_comb begin
		n_sat  = (cfg_q > CFG_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : CNT_W'(cfg_q);
		single = n_sat == CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// stop table, one write port and one registered read port
	assign wr_entry = '{pos: req_beat.stop_position,
	                    col: {req_beat.stop_alpha, req_beat.stop_blue,
	                          req_beat.stop_green, req_beat.stop_red}};

	always_ff @(posedge clk) begin
		if (cmd.wr && (CNT_W'(req_beat.stop_index) < CNT_W'(MAX_STOPS))) begin
			mem[req_beat.stop_index[IDX_W-1:0]] <= wr_entry;
		end
		if (cmd.rd) begin
			rd_s1 <= mem[addr_q];
		end
	end

	// nearest stop below and above the query, first index wins on ties
	always_comb begin
		lo_upd = single || ((rd_s1.pos < qpos_q) && (!have_lo_q || rd_s1.pos > lo_pos_q));
		hi_upd = !single && (rd_s1.pos > qpos_q) && (!have_hi_q || rd_s1.pos < hi_pos_q);
	end

	// interpolation operands
	always_comb begin
		span     = hi_pos_q - lo_pos_q;
		np_q     = hi_pos_q - qpos_q;
		q_pp     = qpos_q - lo_pos_q;
		ge       = rem_q >= NUM_W'(dsh_q);
		quot_nxt = {quot_q[CH_W-2:0], ge};
	end

	// sequencing counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			have_lo_q   <= 1'b0;
			have_hi_q   <= 1'b0;
			ch_q        <= '0;
			bit_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd;
			if (cmd.start) begin
				addr_q    <= '0;
				have_lo_q <= 1'b0;
				have_hi_q <= 1'b0;
			end else begin
				if (cmd.rd) begin
					addr_q <= addr_q + IDX_W'(1);
				end
				if (rd_vld_s1 && lo_upd) begin
					have_lo_q <= 1'b1;
				end
				if (rd_vld_s1 && hi_upd) begin
					have_hi_q <= 1'b1;
				end
			end
			if (cmd.ch_init) begin
				ch_q <= '0;
			end else if (cmd.div && bit_q == '0) begin
				ch_q <= ch_q + CHSEL_W'(1);
			end
			if (cmd.load) begin
				bit_q <= BIT_W'(CH_W - 1);
			end else if (cmd.div) begin
				bit_q <= bit_q - BIT_W'(1);
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// bounding stops, products, divider and result holding registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qpos_q <= req_beat.query_position;
		end
		if (rd_vld_s1 && lo_upd) begin
			lo_pos_q <= rd_s1.pos;
			lo_col_q <= rd_s1.col;
		end
		if (rd_vld_s1 && hi_upd) begin
			hi_pos_q <= rd_s1.pos;
			hi_col_q <= rd_s1.col;
		end
		if (cmd.mul) begin
			prod_a_s1 <= PROD_W'(lo_col_q[ch_q]) * PROD_W'(np_q);
			prod_b_s1 <= PROD_W'(hi_col_q[ch_q]) * PROD_W'(q_pp);
		end
		if (cmd.load) begin
			rem_q  <= NUM_W'(prod_a_s1) + NUM_W'(prod_b_s1) + NUM_W'(span >> 1);
			dsh_q  <= DSH_W'(span) << (CH_W - 1);
			quot_q <= '0;
		end else if (cmd.div) begin
			if (ge) begin
				rem_q <= rem_q - NUM_W'(dsh_q);
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= quot_nxt;
		end
		if (cmd.start) begin
			rslt_vld_q <= 1'b0;
			rslt_col_q <= '0;
		end else if (cmd.pick) begin
			if (have_lo_q && !have_hi_q) begin
				rslt_vld_q <= 1'b1;
				rslt_col_q <= lo_col_q;
			end else if (have_hi_q && !have_lo_q) begin
				rslt_vld_q <= 1'b1;
				rslt_col_q <= hi_col_q;
			end
		end else if (cmd.ch_init) begin
			rslt_vld_q <= 1'b1;
		end else if (cmd.div && bit_q == '0) begin
			rslt_col_q[ch_q] <= quot_nxt;
		end
		if (cmd.emit) begin
			out_q <= '{color_valid: rslt_vld_q,
			           out_red:     rslt_col_q[0],
			           out_green:   rslt_col_q[1],
			           out_blue:    rslt_col_q[2],
			           out_alpha:   rslt_col_q[3]};
		end
	end

	// status back to the controller
	always_comb begin
		stat.n_zero    = n_sat == '0;
		stat.scan_last = CNT_W'(addr_q) == (n_sat - CNT_W'(1));
		stat.have_lo   = have_lo_q;
		stat.have_hi   = have_hi_q;
		stat.div_last  = bit_q == '0;
		stat.ch_last   = ch_q == CHSEL_W'(NUM_CH - 1);
		stat.out_busy  = rsp_valid_q && !rsp_ready;
	end

	assign rsp_beat  = out_q;
	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/gradient_stop_color_lookup_core.sv */
// ----------------------------------------------------------------------------
// gradient_stop_color_lookup_core: gradient stop color lookup
// Stores gradient stops and returns the color at a query position, linearly
// interpolated between the nearest stops below and above it.
// ----------------------------------------------------------------------------
//  channel  | kind        | beat
//  req      | valid/ready | command, stop write fields, query position
//  rsp      | valid/ready | color_valid and RGBA, one beat per lookup
//  cfg      | write only  | stops_in_use
//
//  a stop write is done on acceptance; a lookup steps through accept, reads of
//  the n stops in use, drain and evaluate, then per channel multiply, load and
//  an 8-step divider, and finally loads the response register once rsp is free
//  one-sided lookups skip the channel steps, an empty table goes straight to done
//  the response register lets a new request in while a color waits on rsp
//  arst_n clears the controller, counters and stop count; the table is not
//  cleared and holds garbage until written
// ----------------------------------------------------------------------------
module gradient_stop_color_lookup_core (
	input  logic                        clk,
	input  logic                        arst_n,
	gscl_req_if.sink                    req,
	gscl_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [gscl_pkg::CFG_W-1:0]  cfg_wdata
);
	import gscl_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer
	gscl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.payload.command),
		.req_ready   (req.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// table and arithmetic
	gscl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_beat  (req.payload),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_beat  (rsp.payload),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

	// an invalid color carries zero channels
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.payload.color_valid |->
			rsp.payload.out_red == '0 && rsp.payload.out_green == '0 &&
			rsp.payload.out_blue == '0 && rsp.payload.out_alpha == '0)
		else $error("invalid color with nonzero channels");

	// a lookup keeps the request side closed on the next cycle
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.payload.command == CMD_LOOKUP |=> !req.ready)
		else $error("request accepted during a lookup");

	// the response register is never overwritten while its beat waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !rsp.valid || rsp.ready)
		else $error("pending color overwritten");

	// interpolation only runs with stops on both sides
	a_both_sides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> stat.have_lo && stat.have_hi)
		else $error("interpolation without two bounding stops");

endmodule

/* tb/sv/gradient_stop_color_lookup_core_tb.sv */
// ----------------------------------------------------------------------------
// gradient_stop_color_lookup_core_tb: self-checking bench for the stop lookup
// Fills the stop table, sweeps the stop count through its range, and checks
// every color beat against an in-bench interpolation model. A directed table
// covers empty and single-stop tables, ties, queries at stops and at the ends,
// and rounding. Random traffic with random pacing on both channels follows.
// ----------------------------------------------------------------------------
module gradient_stop_color_lookup_core_tb;
	import gscl_pkg::*;

	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 10;
	localparam int PHASE_BEATS    = 123;

	localparam rsp_beat_t NO_COLOR = '0;

	typedef enum logic {ROW_BEAT, ROW_STOPS} plan_kind_t;

	typedef struct {
		plan_kind_t       kind;
		logic [CFG_W-1:0] stops;
		req_beat_t        beat;
		bit               typed;
		rsp_beat_t        want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	gscl_req_if req_ch ();
	gscl_rsp_if rsp_ch ();

	gradient_stop_color_lookup_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// model of the stop table and stop count
	logic [POS_W-1:0] model_pos [MAX_STOPS];
	chan_t            model_ch [MAX_STOPS][NUM_CH];
	logic [CFG_W-1:0] model_stop_count;

	rsp_beat_t pending_colors [$];
	plan_row_t directed_plan [$];
	int        error_count   = 0;
	int        stall_cycles  = 0;
	int        send_gap_pct  = 0;
	int        rsp_gap_pct   = 0;
	bit        hold_rsp      = 0;
	int        phase_stops [PHASES] = '{16, 2, 31, 1, 17, 3, 0, 8, 16, 5};

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// color at a query: nearest stop strictly below and above, rounded blend
	function automatic bit predict_color(input req_beat_t b, output rsp_beat_t r);
		int unsigned n, q, lo, hi, pp, np, d, v;
		bit          have_lo, have_hi;
		chan_t       mix [NUM_CH];
		r = NO_COLOR;
		have_lo = 1'b0;
		have_hi = 1'b0;
		lo = 0;
		hi = 0;
		if (b.command == CMD_WRITE) begin
			model_pos[b.stop_index] = b.stop_position;
			model_ch[b.stop_index] = '{b.stop_red, b.stop_green, b.stop_blue, b.stop_alpha};
			return 1'b0;
		end
		n = (model_stop_count > MAX_STOPS) ? MAX_STOPS : model_stop_count;
		q = b.query_position;
		if (n == 0)
			return 1'b1;
		if (n == 1) begin
			mix = model_ch[0];
		end else begin
			for (int i = 0; i < n; i++) begin
				if (model_pos[i] < q && (!have_lo || model_pos[i] > model_pos[lo])) begin
					have_lo = 1'b1;
					lo = i;
				end
				if (model_pos[i] > q && (!have_hi || model_pos[i] < model_pos[hi])) begin
					have_hi = 1'b1;
					hi = i;
				end
			end
			// every stop sits on the query
			if (!have_lo && !have_hi)
				return 1'b1;
			if (!have_hi) begin
				mix = model_ch[lo];
			end else if (!have_lo) begin
				mix = model_ch[hi];
			end else begin
				pp = model_pos[lo];
				np = model_pos[hi];
				d = np - pp;
				for (int k = 0; k < NUM_CH; k++) begin
					v = model_ch[lo][k] * (np - q) + model_ch[hi][k] * (q - pp);
					mix[k] = chan_t'((v + d / 2) / d);
				end
			end
		end
		r = '{1'b1, mix[0], mix[1], mix[2], mix[3]};
		return 1'b1;
	endfunction

	// directed table rows
	function automatic plan_row_t stop_row(input int idx, input int pos,
			input chan_t red, input chan_t green, input chan_t blue, input chan_t alpha);
		plan_row_t row;
		row = '{kind: ROW_BEAT, stops: '0, beat: '0, typed: 1'b0, want: NO_COLOR};
		row.beat.command       = CMD_WRITE;
		row.beat.stop_index    = 4'(idx);
		row.beat.stop_position = POS_W'(pos);
		row.beat.stop_red      = red;
		row.beat.stop_green    = green;
		row.beat.stop_blue     = blue;
		row.beat.stop_alpha    = alpha;
		return row;
	endfunction

	function automatic plan_row_t query_row(input int q);
		plan_row_t row;
		row = '{kind: ROW_BEAT, stops: '0, beat: '1, typed: 1'b0, want: NO_COLOR};
		row.beat.command        = CMD_LOOKUP;
		row.beat.query_position = POS_W'(q);
		return row;
	endfunction

	function automatic plan_row_t expect_row(input int q, input rsp_beat_t want);
		plan_row_t row;
		row = query_row(q);
		row.typed = 1'b1;
		row.want  = want;
		return row;
	endfunction

	function automatic plan_row_t count_row(input int n);
		plan_row_t row;
		row = '{kind: ROW_STOPS, stops: CFG_W'(n), beat: '0, typed: 1'b0, want: NO_COLOR};
		return row;
	endfunction

	function automatic rsp_beat_t color(input chan_t red, input chan_t green,
			input chan_t blue, input chan_t alpha);
		return '{1'b1, red, green, blue, alpha};
	endfunction

	// random field values, biased toward stops, ends and repeated positions
	function automatic int live_stops();
		return (model_stop_count > MAX_STOPS) ? MAX_STOPS : model_stop_count;
	endfunction

	function automatic logic [POS_W-1:0] random_position();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2, 3: begin
				return POS_W'($urandom_range(0, 4) * 16383);
			end
			4: begin
				return model_pos[$urandom_range(0, MAX_STOPS - 1)] + 1'b1;
			end
			default: begin
				return POS_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	function automatic logic [POS_W-1:0] random_query();
		int live;
		live = (live_stops() > 0) ? $urandom_range(0, live_stops() - 1)
			: $urandom_range(0, MAX_STOPS - 1);
		case ($urandom_range(0, 9))
			4, 5: begin
				return model_pos[live];
			end
			6: begin
				return model_pos[live] + 1'b1;
			end
			7: begin
				return model_pos[live] - 1'b1;
			end
			8: begin
				return '0;
			end
			9: begin
				return '1;
			end
			default: begin
				return POS_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	function automatic chan_t random_channel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return chan_t'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic req_beat_t random_beat();
		req_beat_t b;
		b.command = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_LOOKUP;
		if (live_stops() > 0 && $urandom_range(0, 3) != 0)
			b.stop_index = 4'($urandom_range(0, live_stops() - 1));
		else
			b.stop_index = 4'($urandom_range(0, MAX_STOPS - 1));
		b.stop_position  = random_position();
		b.stop_red       = random_channel();
		b.stop_green     = random_channel();
		b.stop_blue      = random_channel();
		b.stop_alpha     = random_channel();
		b.query_position = random_query();
		return b;
	endfunction

	// offer one request beat, record the color it should produce
	task automatic send_beat(input req_beat_t b, input bit typed, input rsp_beat_t want);
		rsp_beat_t predicted;
		req_ch.valid   <= 1'b1;
		req_ch.payload <= b;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (predict_color(b, predicted))
			pending_colors.push_back(typed ? want : predicted);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop count changes only once the block has gone quiet
	task automatic set_stop_count(input logic [CFG_W-1:0] n);
		req_ch.valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_stop_count = n;
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	// response pacing: short random stalls, one long hold on request
	initial begin : rsp_pacer
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rsp_gap_pct != 0 && $urandom_range(0, 99) < rsp_gap_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each color beat with the oldest pending color
	always @(posedge clk) begin : color_check
		rsp_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_colors.size() == 0) begin
				$error("color beat arrived with no lookup pending");
				error_count++;
			end else begin
				want = pending_colors.pop_front();
				check_field("color_valid", want.color_valid, rsp_ch.payload.color_valid);
				check_field("out_red", want.out_red, rsp_ch.payload.out_red);
				check_field("out_green", want.out_green, rsp_ch.payload.out_green);
				check_field("out_blue", want.out_blue, rsp_ch.payload.out_blue);
				check_field("out_alpha", want.out_alpha, rsp_ch.payload.out_alpha);
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("gradient_stop_color_lookup_core test failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		req_beat_t b;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		model_stop_count = '0;
		foreach (model_pos[i]) begin
			model_pos[i] = '0;
			model_ch[i] = '{default: '0};
		end

		directed_plan = '{
			// empty table
			expect_row(0, NO_COLOR),
			expect_row(65535, NO_COLOR),
			stop_row(0, 16384, 8'hFF, 8'h00, 8'h80, 8'hFF),
			stop_row(1, 49152, 8'h00, 8'hFF, 8'h40, 8'h00),
			stop_row(2, 16384, 8'h11, 8'h22, 8'h33, 8'h44),
			stop_row(3, 65535, 8'h12, 8'h34, 8'h56, 8'h78),
			stop_row(15, 65535, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			// single stop answers every query
			count_row(1),
			expect_row(32768, color(8'hFF, 8'h00, 8'h80, 8'hFF)),
			count_row(4),
			// below all stops, tie on the upper stop goes to the lower index
			expect_row(0, color(8'hFF, 8'h00, 8'h80, 8'hFF)),
			// query on a stop uses the stops strictly around it
			expect_row(16384, color(8'h00, 8'hFF, 8'h40, 8'h00)),
			query_row(20000),
			expect_row(65535, color(8'h00, 8'hFF, 8'h40, 8'h00)),
			query_row(65534),
			// halfway rounding goes up
			stop_row(0, 0, 8'h00, 8'h00, 8'hFF, 8'hFF),
			stop_row(1, 2, 8'h01, 8'h01, 8'h00, 8'h00),
			count_row(2),
			query_row(1),
			expect_row(2, color(8'h00, 8'h00, 8'hFF, 8'hFF)),
			// all stops on the query gives no color
			stop_row(0, 32768, 8'h55, 8'hAA, 8'h55, 8'hAA),
			stop_row(1, 32768, 8'hAA, 8'h55, 8'hAA, 8'h55),
			expect_row(32768, NO_COLOR)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_STOPS)
				set_stop_count(directed_plan[i].stops);
			else
				send_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
		end

		// fill every entry before any wider stop count
		send_gap_pct = 15;
		rsp_gap_pct  = 15;
		for (int i = 0; i < MAX_STOPS; i++) begin
			b = random_beat();
			b.command    = CMD_WRITE;
			b.stop_index = 4'(i);
			send_beat(b, 1'b0, NO_COLOR);
		end

		// random phases over a sweep of stop counts
		for (int p = 0; p < PHASES; p++) begin
			set_stop_count(CFG_W'(phase_stops[p]));
			if (p == PHASES - 1) begin
				send_gap_pct = 0;
				rsp_gap_pct  = 0;
			end else begin
				send_gap_pct = $urandom_range(0, 2) * 15;
				rsp_gap_pct  = $urandom_range(0, 2) * 15;
			end
			// back pressure: responses held while requests keep coming
			if (p == 1) begin
				send_gap_pct = 0;
				hold_rsp = 1'b1;
			end
			for (int i = 0; i < PHASE_BEATS; i++)
				send_beat(random_beat(), 1'b0, NO_COLOR);
		end

		// drain
		req_ch.valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_colors.size() == 0)
			$display("gradient_stop_color_lookup_core test passed");
		else
			$display("gradient_stop_color_lookup_core test failed");
		$finish;
	end

endmodule
